@@ src/pcc_pkg.sv @@
// Package for the pixel channel converter: route modes, register indexes,
// luma constants and the source byte picker. No dependencies.
package pcc_pkg;

   // Default configuration of the block
   localparam int PCC_MAX_CHANNELS = 8;
   localparam int PCC_MAP_ENTRIES  = 256;

   // Register reset values
   localparam logic [47:0] ROUTES_RESET = 48'd249632632406528;
   localparam logic [3:0]  COUNT_RESET  = 4'd4;

   // BT.601 luma weights and the reciprocal of 1000 (exact for sums up to 255000)
   localparam logic [17:0] LUMA_R      = 18'd299;
   localparam logic [17:0] LUMA_G      = 18'd587;
   localparam logic [17:0] LUMA_B      = 18'd114;
   localparam logic [36:0] LUMA_RECIP  = 37'd268436;
   localparam int          LUMA_SHIFT  = 28;

   // Per-lane route mode; code 7 is unused and writes zero
   typedef enum logic [2:0] {
      MODE_COPY = 3'd0,
      MODE_LUMA = 3'd1,
      MODE_MAPR = 3'd2,
      MODE_MAPG = 3'd3,
      MODE_MAPB = 3'd4,
      MODE_ZERO = 3'd5,
      MODE_FULL = 3'd6
   } pcc_mode_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_ROUTES    = 2'd0,
      CSR_IN_COUNT  = 2'd1,
      CSR_OUT_COUNT = 2'd2
   } pcc_csr_type;

   // Colormap write broadcast to every lane copy
   typedef struct packed {
      logic       en;
      logic [7:0] index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pcc_map_wr_type;

   // Byte ch of a pixel, zero at or beyond the valid channel count
   function automatic logic [7:0] pcc_src_byte(input logic [63:0] pix,
                                               input logic [3:0]  ch,
                                               input logic [3:0]  nin);
      logic [7:0] b;
      b = 8'd0;
      if (ch < nin && ch < 4'd8) begin
         b = pix[{ch[2:0], 3'b000} +: 8];
      end
      return b;
   endfunction

endpackage

@@ src/pixel_channel_converter_unit.sv @@
// A pixel item goes through the input register, the lane stage with the
// colormap read and the output register before it shows on rsp_*.
// Throughput: one item per cycle; the pipeline holds only while rsp is stalled.
// Reset: synchronous; clears valids and restores registers, then a clearing pass
// fills all MAP_ENTRIES entries (256 by default) with the gray ramp, req_ready low.
// Top level of the pixel channel converter. Depends on pcc_pkg, pcc_lane.
module pixel_channel_converter_unit
   import pcc_pkg::*;
#(
   parameter int MAX_CHANNELS = PCC_MAX_CHANNELS,
   parameter int MAP_ENTRIES  = PCC_MAP_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [63:0] req_pixel_in,
   input  logic        req_line_end,
   input  logic [7:0]  req_map_index,
   input  logic [7:0]  req_map_red,
   input  logic [7:0]  req_map_green,
   input  logic [7:0]  req_map_blue,
   // results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_pixel_out,
   output logic        rsp_last_in_line
);

   localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

   logic        en;
   logic [47:0] routes_ff;
   logic [3:0]  in_count_ff, out_count_ff;
   logic [3:0]  nin, nout;

   logic          init_busy_ff;
   logic [AW-1:0] init_addr_ff;

   logic        a_valid_ff, a_func_ff, a_line_end_ff;
   logic [63:0] a_pixel_ff;
   logic [7:0]  a_index_ff, a_red_ff, a_green_ff, a_blue_ff;
   logic        b_valid_ff, b_line_end_ff;
   logic        rsp_valid_ff, rsp_last_ff;
   logic [63:0] rsp_pixel_ff;
   logic [63:0] lanes;

   pcc_map_wr_type map_wr;

   // Whole pipeline advances unless a result is stalled
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en && !init_busy_ff;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         routes_ff    <= ROUTES_RESET;
         in_count_ff  <= COUNT_RESET;
         out_count_ff <= COUNT_RESET;
      end else if (csr_valid) begin
         case (pcc_csr_type'(csr_index))
            CSR_ROUTES:    routes_ff    <= csr_wdata;
            CSR_IN_COUNT:  in_count_ff  <= csr_wdata[3:0];
            CSR_OUT_COUNT: out_count_ff <= csr_wdata[3:0];
            default:       ;
         endcase
      end
   end

   // Counts saturate at the lane count
   assign nin  = (in_count_ff > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : in_count_ff;
   assign nout = (out_count_ff > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : out_count_ff;

   // Clearing pass: entry i gets gray i, one entry per cycle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         init_busy_ff <= 1'b1;
         init_addr_ff <= '0;
      end else if (init_busy_ff) begin
         init_addr_ff <= init_addr_ff + AW'(1);
         if (init_addr_ff == AW'(MAP_ENTRIES - 1)) begin
            init_busy_ff <= 1'b0;
         end
      end
   end

   // Stage A: input register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid && req_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_func_ff     <= req_func;
         a_pixel_ff    <= req_pixel_in;
         a_line_end_ff <= req_line_end;
         a_index_ff    <= req_map_index;
         a_red_ff      <= req_map_red;
         a_green_ff    <= req_map_green;
         a_blue_ff     <= req_map_blue;
      end
   end

   // Colormap load, written as the item leaves stage A; the clearing pass
   // owns the write port until it is done
   always_comb begin
      if (init_busy_ff) begin
         map_wr.en    = 1'b1;
         map_wr.index = 8'(init_addr_ff);
         map_wr.red   = 8'(init_addr_ff);
         map_wr.green = 8'(init_addr_ff);
         map_wr.blue  = 8'(init_addr_ff);
      end else begin
         map_wr.en    = en && a_valid_ff && a_func_ff;
         map_wr.index = a_index_ff;
         map_wr.red   = a_red_ff;
         map_wr.green = a_green_ff;
         map_wr.blue  = a_blue_ff;
      end
   end

   // Stage B: only pixel items go on to a result
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff && !a_func_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_line_end_ff <= a_line_end_ff;
      end
   end

   // Output lanes
   for (genvar k = 0; k < 8; k++) begin : g_lane
      if (k < MAX_CHANNELS) begin : g_on
         pcc_lane #(
            .MAP_ENTRIES(MAP_ENTRIES)
         ) u_lane (
            .clock    (clock),
            .en       (en),
            .a_pixel  (a_pixel_ff),
            .route    (routes_ff[6*k +: 6]),
            .nin      (nin),
            .lane_on  (4'(k) < nout),
            .map_wr   (map_wr),
            .lane_byte(lanes[8*k +: 8])
         );
      end else begin : g_off
         assign lanes[8*k +: 8] = 8'd0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_pixel_ff <= lanes;
         rsp_last_ff  <= b_line_end_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = rsp_pixel_ff;
   assign rsp_last_in_line = rsp_last_ff;

endmodule

@@ src/pcc_lane.sv @@
// One output lane: source byte select, luma sum, private colormap copy,
// and the final byte mux. Depends on pcc_pkg.
module pcc_lane
   import pcc_pkg::*;
#(
   parameter int MAP_ENTRIES = PCC_MAP_ENTRIES
) (
   input  logic           clock,
   input  logic           en,
   input  logic [63:0]    a_pixel,
   input  logic [5:0]     route,
   input  logic [3:0]     nin,
   input  logic           lane_on,
   input  pcc_map_wr_type map_wr,
   output logic [7:0]     lane_byte
);

   localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

   logic [23:0]            cmap [MAP_ENTRIES];

   pcc_mode_type mode;
   logic [3:0]   src;
   logic [7:0]   b0, b1, b2;
   logic [17:0]  luma_sum_in;
   logic         rd_hit_in, wr_hit;
   logic [AW-1:0] rd_addr, wr_addr;

   pcc_mode_type mode_ff;
   logic [7:0]   copy_ff;
   logic [17:0]  luma_ff;
   logic         hit_ff;
   logic [23:0]  rd_data_ff;

   logic [36:0]  luma_prod;
   logic [7:0]   luma;
   logic [23:0]  entry;

   // Route decode and the three source bytes
   always_comb begin
      mode        = pcc_mode_type'(route[2:0]);
      src         = {1'b0, route[5:3]};
      b0          = pcc_src_byte(a_pixel, src, nin);
      b1          = pcc_src_byte(a_pixel, src + 4'd1, nin);
      b2          = pcc_src_byte(a_pixel, src + 4'd2, nin);
      luma_sum_in = 18'(b0) * LUMA_R + 18'(b1) * LUMA_G + 18'(b2) * LUMA_B;
      rd_hit_in   = {1'b0, b0} < 9'(MAP_ENTRIES);
      rd_addr     = b0[AW-1:0];
      wr_hit      = {1'b0, map_wr.index} < 9'(MAP_ENTRIES);
      wr_addr     = map_wr.index[AW-1:0];
   end

   // Colormap copy: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (map_wr.en && wr_hit) begin
         cmap[wr_addr] <= {map_wr.red, map_wr.green, map_wr.blue};
      end
      if (en) begin
         rd_data_ff <= cmap[rd_addr];
      end
   end

   // Stage B registers
   always_ff @(posedge clock) begin
      if (en) begin
         mode_ff <= lane_on ? mode : MODE_ZERO;
         copy_ff <= b0;
         luma_ff <= luma_sum_in;
         hit_ff  <= rd_hit_in;
      end
   end

   // Divide by 1000 through the reciprocal, then pick the lane byte
   always_comb begin
      luma_prod = 37'(luma_ff) * LUMA_RECIP;
      luma      = luma_prod[LUMA_SHIFT +: 8];
      entry     = rd_data_ff;
      case (mode_ff)
         MODE_COPY: lane_byte = copy_ff;
         MODE_LUMA: lane_byte = luma;
         MODE_MAPR: lane_byte = hit_ff ? entry[23:16] : 8'd0;
         MODE_MAPG: lane_byte = hit_ff ? entry[15:8] : 8'd0;
         MODE_MAPB: lane_byte = hit_ff ? entry[7:0] : 8'd0;
         MODE_FULL: lane_byte = 8'hFF;
         default:   lane_byte = 8'd0;
      endcase
   end

endmodule

@@ src/pcc_checker.sv @@
// Port-level checks for the pixel channel converter, bound to the top level.
// Depends on pixel_channel_converter_unit.
module pcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_pixel_out,
   input logic        rsp_last_in_line
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out)
                                  && $stable(rsp_last_in_line))
      else $error("stalled result changed");

   // Reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds off the input
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result stalled");

endmodule

bind pixel_channel_converter_unit pcc_checker u_pcc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pixel_out   (rsp_pixel_out),
   .rsp_last_in_line(rsp_last_in_line)
);

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Testbench for pixel_channel_converter_unit: directed and random pixel and
// colormap-load items, each result checked against a predictor kept here.
// Depends on pcc_pkg and the converter RTL.
module tb
   import pcc_pkg::*;
();

   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int HOLD_CYCLES      = 300;
   localparam int SHOWN_MISMATCHES = 10;
   localparam int RANDOM_PHASES    = 6;
   localparam int PHASE_ITEMS      = 200;
   localparam int IDLE_TAIL        = 4;

   localparam logic        FUNC_CONVERT     = 1'b0;
   localparam logic        FUNC_MAP_LOAD    = 1'b1;
   localparam logic [1:0]  CSR_SPARE        = 2'd3;
   localparam logic [2:0]  MODE_SPARE       = 3'd7;
   localparam logic [47:0] ROUTES_AT_RESET  = 48'd249632632406528;
   localparam logic [3:0]  COUNT_AT_RESET   = 4'd4;

   typedef struct {
      logic [63:0] pixel;
      logic        last;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [63:0] req_pixel_in = '0;
   logic        req_line_end = 1'b0;
   logic [7:0]  req_map_index = '0;
   logic [7:0]  req_map_red = '0;
   logic [7:0]  req_map_green = '0;
   logic [7:0]  req_map_blue = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_pixel_out;
   logic        rsp_last_in_line;

   // predictor copy of the registers and the colormap
   logic [47:0] pred_routes;
   logic [3:0]  pred_in_count;
   logic [3:0]  pred_out_count;
   logic [7:0]  cmap_red [256];
   logic [7:0]  cmap_green [256];
   logic [7:0]  cmap_blue [256];

   pixel_result_type pending_pixels [$];

   int   mismatch_count = 0;
   int   req_gap_pct = 0;
   int   rsp_stall_pct = 0;
   logic hold_request = 1'b0;
   int   hold_left = 0;
   int   stall_left = 0;
   int   idle_cycles = 0;

   pixel_channel_converter_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_pixel_in     (req_pixel_in),
      .req_line_end     (req_line_end),
      .req_map_index    (req_map_index),
      .req_map_red      (req_map_red),
      .req_map_green    (req_map_green),
      .req_map_blue     (req_map_blue),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_last_in_line (rsp_last_in_line)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int clamp_count(logic [3:0] n);
      return (n > 4'd8) ? 8 : int'(n);
   endfunction

   // source byte, zero at or beyond the input count or past byte 7
   function automatic logic [7:0] pick_byte(logic [63:0] pix, int ch, int nin);
      if (ch >= nin || ch >= 8) return 8'd0;
      return pix[8*ch +: 8];
   endfunction

   function automatic logic [63:0] convert_pixel(logic [63:0] pix);
      int          nin;
      int          nout;
      int          src;
      int          sum;
      logic [2:0]  mode;
      logic [7:0]  v;
      logic [63:0] res;
      nin  = clamp_count(pred_in_count);
      nout = clamp_count(pred_out_count);
      res  = '0;
      for (int k = 0; k < nout; k++) begin
         mode = pred_routes[6*k +: 3];
         src  = int'(pred_routes[6*k+3 +: 3]);
         case (mode)
            MODE_COPY: v = pick_byte(pix, src, nin);
            MODE_LUMA: begin
               sum = 299 * int'(pick_byte(pix, src, nin))
                   + 587 * int'(pick_byte(pix, src + 1, nin))
                   + 114 * int'(pick_byte(pix, src + 2, nin));
               v = 8'(sum / 1000);
            end
            MODE_MAPR: v = cmap_red[pick_byte(pix, src, nin)];
            MODE_MAPG: v = cmap_green[pick_byte(pix, src, nin)];
            MODE_MAPB: v = cmap_blue[pick_byte(pix, src, nin)];
            MODE_FULL: v = 8'hFF;
            default:   v = 8'h00;   // zero mode and the spare code
         endcase
         res[8*k +: 8] = v;
      end
      return res;
   endfunction

   task automatic reset_predictor();
      pred_routes    = ROUTES_AT_RESET;
      pred_in_count  = COUNT_AT_RESET;
      pred_out_count = COUNT_AT_RESET;
      for (int i = 0; i < 256; i++) begin
         cmap_red[i]   = 8'(i);
         cmap_green[i] = 8'(i);
         cmap_blue[i]  = 8'(i);
      end
   endtask

   // ---------------------------------------------------------------- helpers

   // a gap only with chance pct percent; then mostly short, rarely long
   function automatic int pick_gap(int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   // bytes biased toward 0 and 255
   function automatic logic [63:0] rand_pixel();
      logic [63:0] p;
      for (int c = 0; c < 8; c++) begin
         case ($urandom_range(0, 5))
            0:       p[8*c +: 8] = 8'h00;
            1:       p[8*c +: 8] = 8'hFF;
            default: p[8*c +: 8] = 8'($urandom);
         endcase
      end
      return p;
   endfunction

   function automatic logic [47:0] rand_routes();
      logic [47:0] r;
      for (int k = 0; k < 8; k++) r[6*k +: 6] = 6'($urandom);
      return r;
   endfunction

   function automatic logic [3:0] rand_count();
      if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
      return 4'($urandom_range(1, 8));
   endfunction

   // send one item; valid stays up across back-to-back items
   task automatic send_item(logic func, logic [63:0] pix, logic last,
                            logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b);
      int gap;
      gap = pick_gap(req_gap_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_pixel_in  <= pix;
      req_line_end  <= last;
      req_map_index <= idx;
      req_map_red   <= r;
      req_map_green <= g;
      req_map_blue  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (func == FUNC_MAP_LOAD) begin
         cmap_red[idx]   = r;
         cmap_green[idx] = g;
         cmap_blue[idx]  = b;
      end else begin
         pending_pixels.push_back(pixel_result_type'{convert_pixel(pix), last});
      end
   endtask

   task automatic send_pixel(logic [63:0] pix, logic last);
      send_item(FUNC_CONVERT, pix, last, 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom));
   endtask

   task automatic send_map(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b);
      send_item(FUNC_MAP_LOAD, {$urandom, $urandom}, 1'($urandom), idx, r, g, b);
   endtask

   // drain all results, then let a trailing map load settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [47:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_ROUTES:    pred_routes    = data;
         CSR_IN_COUNT:  pred_in_count  = data[3:0];
         CSR_OUT_COUNT: pred_out_count = data[3:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [47:0] routes, logic [3:0] nin, logic [3:0] nout);
      wait_idle();
      csr_write(CSR_ROUTES, routes);
      csr_write(CSR_IN_COUNT, 48'(nin));
      csr_write(CSR_OUT_COUNT, 48'(nout));
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- result side

   task automatic check_result();
      pixel_result_type exp_res;
      if (pending_pixels.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= SHOWN_MISMATCHES)
            $display("result without a pending pixel: got %h/%b",
                     rsp_pixel_out, rsp_last_in_line);
         return;
      end
      exp_res = pending_pixels.pop_front();
      if (rsp_pixel_out !== exp_res.pixel || rsp_last_in_line !== exp_res.last) begin
         mismatch_count++;
         if (mismatch_count <= SHOWN_MISMATCHES)
            $display("result mismatch: pixel_out exp %h got %h, last_in_line exp %b got %b",
                     exp_res.pixel, rsp_pixel_out, exp_res.last, rsp_last_in_line);
      end
   endtask

   // checker plus receiver stalls and the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request <= 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap(rsp_stall_pct);
         end
      end
   end

   // watchdog: cycles with no handshake on any channel
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   // reset routing: lanes 0..3 copy channels 0..3
   task automatic test_reset_config();
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      send_pixel(64'h0, 1'b0);
      send_pixel('1, 1'b1);
      send_pixel(64'h8877_6655_4433_2211, 1'b1);
      send_pixel(64'hAA55_AA55_55AA_55AA, 1'b0);
   endtask

   // one lane per mode, including the spare code
   task automatic test_every_mode();
      logic [47:0] r;
      send_map(8'h00, 8'hFF, 8'h00, 8'h80);
      send_map(8'hFF, 8'h01, 8'h02, 8'h03);
      send_map(8'h7F, 8'($urandom), 8'($urandom), 8'($urandom));
      r[5:0]   = {3'd7, MODE_COPY};
      r[11:6]  = {3'd0, MODE_LUMA};
      r[17:12] = {3'd1, MODE_MAPR};
      r[23:18] = {3'd2, MODE_MAPG};
      r[29:24] = {3'd3, MODE_MAPB};
      r[35:30] = {3'd4, MODE_ZERO};
      r[41:36] = {3'd5, MODE_FULL};
      r[47:42] = {3'd6, MODE_SPARE};
      set_config(r, 4'd8, 4'd8);
      send_pixel('1, 1'b1);
      send_pixel(64'h0, 1'b0);
      send_pixel(64'h5A00_FF7F_FF00_7F00, 1'b1);
      send_pixel(64'hFF00_0000_7F00_FFFF, 1'b0);
   endtask

   // source and lane limits, count saturation, zero counts, spare register
   task automatic test_range_limits();
      logic [47:0] r;
      // luma reaching past byte 7
      r = '0;
      r[5:0]   = {3'd6, MODE_LUMA};
      r[11:6]  = {3'd7, MODE_LUMA};
      r[17:12] = {3'd7, MODE_COPY};
      set_config(r, 4'd8, 4'd3);
      send_pixel('1, 1'b1);
      // sources past the input count, lanes past the output count
      set_config(ROUTES_AT_RESET, 4'd3, 4'd2);
      send_pixel(rand_pixel(), 1'b0);
      set_config({8{3'd2, MODE_LUMA}}, 4'd3, 4'd8);
      send_pixel('1, 1'b1);
      // counts above the channel limit saturate
      set_config(rand_routes(), 4'd15, 4'd15);
      send_pixel(rand_pixel(), 1'b1);
      send_pixel(rand_pixel(), 1'b0);
      // zero input count: every source reads zero, map lookups hit entry 0
      set_config({3'd0, MODE_MAPR, 3'd1, MODE_MAPG, 3'd2, MODE_MAPB, 3'd3, MODE_COPY,
                  3'd4, MODE_LUMA, 3'd5, MODE_FULL, 3'd6, MODE_MAPR, 3'd7, MODE_COPY},
                 4'd0, 4'd8);
      send_pixel('1, 1'b0);
      // zero output count
      set_config({8{3'd0, MODE_FULL}}, 4'd8, 4'd0);
      send_pixel('1, 1'b1);
      // every lane on the spare mode
      set_config('1, 4'd8, 4'd8);
      send_pixel(rand_pixel(), 1'b0);
      // writes to the spare register index change nothing
      wait_idle();
      csr_write(CSR_SPARE, {$urandom, $urandom});
      csr_valid <= 1'b0;
      send_pixel(rand_pixel(), 1'b1);
   endtask

   // random configs and traffic, with colormap loads and read-after-load
   task automatic test_random_traffic();
      logic [7:0] idx;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            set_config(rand_routes(), 4'd8, 4'd8);
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end else begin
            set_config(rand_routes(), rand_count(), rand_count());
            req_gap_pct   = 10 * $urandom_range(0, 6);
            rsp_stall_pct = 10 * $urandom_range(0, 6);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 12) begin
               idx = 8'($urandom);
               send_map(idx, 8'($urandom), 8'($urandom), 8'($urandom));
               if ($urandom_range(0, 1) == 1) send_pixel({8{idx}}, 1'($urandom));
            end else begin
               send_pixel(rand_pixel(), 1'($urandom));
            end
         end
      end
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_output_backpressure();
      set_config(rand_routes(), 4'd8, 4'd8);
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      hold_request <= 1'b1;
      for (int n = 0; n < 40; n++) send_pixel(rand_pixel(), 1'($urandom));
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      for (int n = 0; n < 10; n++) send_pixel(rand_pixel(), 1'($urandom));
   endtask

   initial begin
      reset_predictor();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_config();
      test_every_mode();
      test_range_limits();
      test_random_traffic();
      test_output_backpressure();
      wait_idle();
      repeat (IDLE_TAIL) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ files.f @@
src/pcc_pkg.sv
src/pcc_lane.sv
src/pixel_channel_converter_unit.sv
src/pcc_checker.sv
test/tb.sv
